[src/ffca_pkg.sv]
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared widths, codes and types of the first-fit chunk allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int REQ_W    = 20;  // requested bytes
  localparam int HANDLE_W = 6;   // handle and chunk index fields
  localparam int SIZE_W   = 21;  // stored chunk size
  localparam int STATUS_W = 3;

  localparam int S_TDATA_W = 32;  // req_size, handle, zero fill
  localparam int M_TDATA_W = 32;  // chunk_index, granted_size, zero fill

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED    = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_FREED     = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO      = 3'd4,
    ST_BADHANDLE = 3'd5
  } status_t;

endpackage

[src/ffca_ram.sv]
// ----------------------------------------------------------------------------
// ffca_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ffca_round.sv]
// ----------------------------------------------------------------------------
// ffca_round
// Rounds a request up to a whole number of words. A power-of-two word size
// adds and masks straight into need; any other size uses a constant
// reciprocal multiplication through the padded, prod and need registers.
// ----------------------------------------------------------------------------
module ffca_round #(
  parameter int WORD_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ffca_pkg::REQ_W-1:0]  req,
  output logic                      done,
  output logic [ffca_pkg::SIZE_W-1:0] need
);

  import ffca_pkg::*;

  generate
    if ((WORD_BYTES & (WORD_BYTES - 1)) == 0) begin : g_pow2
      localparam logic [SIZE_W-1:0] ADD  = SIZE_W'(WORD_BYTES - 1);
      localparam logic [SIZE_W-1:0] MASK = ~ADD;

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          need <= (SIZE_W'(req) + ADD) & MASK;
        end
      end
    end else begin : g_recip
      // word count is (padded * RECIP) >> SHIFT, exact for any padded value
      // below 2**SIZE_W
      localparam int SHIFT  = SIZE_W + $clog2(WORD_BYTES);
      localparam int PROD_W = 2 * SIZE_W + 1;
      localparam logic [SIZE_W:0] RECIP =
        (SIZE_W+1)'(((1 << SHIFT) + WORD_BYTES - 1) / WORD_BYTES);
      localparam logic [SIZE_W-1:0] ADD = SIZE_W'(WORD_BYTES - 1);

      logic              stage1;
      logic              stage2;
      logic [SIZE_W-1:0] padded;
      logic [PROD_W-1:0] prod;

      always_ff @(posedge clk) begin
        if (rst) begin
          stage1 <= 1'b0;
          stage2 <= 1'b0;
          done   <= 1'b0;
        end else begin
          stage1 <= start;
          stage2 <= stage1;
          done   <= stage2;
        end
        if (start) begin
          padded <= SIZE_W'(req) + ADD;
        end
        // constant multiplies only
        if (stage1) begin
          prod <= PROD_W'(padded) * PROD_W'(RECIP);
        end
        if (stage2) begin
          need <= SIZE_W'(prod[PROD_W-1:SHIFT]) * SIZE_W'(WORD_BYTES);
        end
      end
    end
  endgenerate

endmodule

[src/first_fit_chunk_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator
// First-fit chunk table: allocate reuses the first free chunk big enough or
// appends a new one, free marks a chunk free by its handle.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. A free, a bad handle and a zero
// size request go from acceptance straight to S_DONE, which passes the
// result to the output register. An allocate first rounds the request, then
// walks the chunk table through the size and free memories, one entry per
// cycle, reads pipelined against the fit compare, and stops at the first
// fit. The block takes one transaction at a time; s_tready is high only
// while it waits for work, but a finished result sits in the output
// register so the next request can be taken while the result waits for
// m_tready. The table memories have no reset: only entries below the chunk
// count are ever checked, and each is written when it is appended.
module first_fit_chunk_allocator #(
  parameter int MAX_CHUNKS = 64,
  parameter int WORD_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ffca_pkg::S_TDATA_W-1:0] s_tdata,  // req_size[19:0], handle[25:20], zero
  input  logic                          s_tuser,   // op
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ffca_pkg::M_TDATA_W-1:0] m_tdata,  // chunk_index[5:0], granted_size[26:6], zero
  output logic [ffca_pkg::STATUS_W-1:0] m_tuser    // status
);

  import ffca_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHUNKS);
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
  localparam int PAD_W = M_TDATA_W - HANDLE_W - SIZE_W;

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_SCAN, S_DONE} state_t;

  state_t state;

  // table bookkeeping
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_idx;     // next entry to read
  logic             chk_valid;  // memory data belongs to chk_idx
  logic [IDX_W-1:0] chk_idx;

  // pending result and output register
  status_t             res_status;
  logic [HANDLE_W-1:0] res_idx;
  logic [SIZE_W-1:0]   res_size;
  status_t             out_status;
  logic [HANDLE_W-1:0] out_idx;
  logic [SIZE_W-1:0]   out_size;

  // input fields
  logic                in_op;
  logic [REQ_W-1:0]    in_req;
  logic [HANDLE_W-1:0] in_handle;
  logic                accept;

  // rounding unit
  logic              rnd_start;
  logic              rnd_done;
  logic [SIZE_W-1:0] need;

  // memories
  logic              size_we;
  logic [IDX_W-1:0]  size_waddr;
  logic [IDX_W-1:0]  raddr;
  logic [SIZE_W-1:0] size_rd;
  logic              free_we;
  logic [IDX_W-1:0]  free_waddr;
  logic              free_wdata;
  logic              free_rd;

  // scan decisions
  logic hit;
  logic scan_end;
  logic full;
  logic handle_ok;
  logic issue;

  assign in_op     = s_tuser;
  assign in_req    = s_tdata[REQ_W-1:0];
  assign in_handle = s_tdata[REQ_W +: HANDLE_W];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  assign rnd_start = accept && (in_op == OP_ALLOC) && (in_req != '0);

  assign handle_ok = CMP_W'(in_handle) < CMP_W'(count);
  assign full      = (count == CNT_W'(MAX_CHUNKS));
  assign issue     = (rd_idx < count);
  // first fit: free and at least the rounded request
  assign hit       = chk_valid && free_rd && (size_rd >= need);
  assign scan_end  = (rd_idx == count);
  assign raddr     = issue ? rd_idx[IDX_W-1:0] : '0;

  // table writes: append, reuse mark and free mark
  always_comb begin
    size_we    = 1'b0;
    size_waddr = count[IDX_W-1:0];
    free_we    = 1'b0;
    free_waddr = count[IDX_W-1:0];
    free_wdata = 1'b0;
    if (state == S_SCAN) begin
      if (hit) begin
        free_we    = 1'b1;
        free_waddr = chk_idx;
      end else if (scan_end && !full) begin
        size_we = 1'b1;
        free_we = 1'b1;
      end
    end else if (accept && in_op == OP_FREE && handle_ok) begin
      free_we    = 1'b1;
      free_waddr = IDX_W'(in_handle);
      free_wdata = 1'b1;
    end
  end

  ffca_round #(
    .WORD_BYTES (WORD_BYTES)
  ) u_round (
    .clk   (clk),
    .rst   (rst),
    .start (rnd_start),
    .req   (in_req),
    .done  (rnd_done),
    .need  (need)
  );

  ffca_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_CHUNKS)
  ) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (need),
    .raddr (raddr),
    .rdata (size_rd)
  );

  ffca_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CHUNKS)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (raddr),
    .rdata (free_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // output register loads from S_DONE, empties on m_tready
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_op == OP_FREE) begin
              state    <= S_DONE;
              res_size <= '0;
              if (handle_ok) begin
                res_status <= ST_FREED;
                res_idx    <= in_handle;
              end else begin
                res_status <= ST_BADHANDLE;
                res_idx    <= '0;
              end
            end else if (in_req == '0) begin
              state      <= S_DONE;
              res_status <= ST_ZERO;
              res_idx    <= '0;
              res_size   <= '0;
            end else begin
              state <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          if (rnd_done) begin
            state     <= S_SCAN;
            rd_idx    <= '0;
            chk_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          // nothing left to check once the scan stops
          chk_valid <= issue && !hit;
          chk_idx   <= rd_idx[IDX_W-1:0];
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (hit) begin
            state      <= S_DONE;
            res_status <= ST_REUSED;
            res_idx    <= HANDLE_W'(chk_idx);
            res_size   <= size_rd;
          end else if (scan_end) begin
            state <= S_DONE;
            if (full) begin
              res_status <= ST_FULL;
              res_idx    <= '0;
              res_size   <= '0;
            end else begin
              res_status <= ST_APPENDED;
              res_idx    <= HANDLE_W'(count);
              res_size   <= need;
              count      <= count + CNT_W'(1);
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state      <= S_IDLE;
            out_status <= res_status;
            out_idx    <= res_idx;
            out_size   <= res_size;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_size, out_idx};
  assign m_tuser = out_status;

endmodule

[src/ffca_checker.sv]
// ----------------------------------------------------------------------------
// ffca_checker
// Port-level checks of the first-fit chunk allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffca_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [ffca_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ffca_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [ffca_pkg::STATUS_W-1:0] m_tuser
);

  import ffca_pkg::*;

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

  // errors carry neither index nor size
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_ZERO || m_tuser == ST_BADHANDLE)
      |-> m_tdata[HANDLE_W+SIZE_W-1:0] == '0)
    else $error("error result with nonzero index or size");

  // a free grants no size
  a_free_no_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FREED |-> m_tdata[HANDLE_W +: SIZE_W] == '0)
    else $error("free result with nonzero size");

  // a granted chunk is never empty
  a_grant_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_REUSED || m_tuser == ST_APPENDED)
      |-> m_tdata[HANDLE_W +: SIZE_W] != '0)
    else $error("grant with zero size");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind first_fit_chunk_allocator ffca_checker u_ffca_checker (.*);
